### hdl/sims_pkg.sv
// ----------------------------------------------------------------------------
// Sorted sequence store package
// Shared types and constants for the sorted sequence store: command and
// result words, the per-cell control word and its operation codes.
// ----------------------------------------------------------------------------
package sims_pkg;

  // Width of a stored value, fixed by the word format.
  localparam int VALUE_W = 32;
  // Width of the insert position field.
  localparam int POS_W = 6;
  // Index and count width, large enough for a count of up to 64 entries.
  localparam int IDX_W = 7;

  localparam logic ACTION_INSERT = 1'b0;
  localparam logic ACTION_SORT   = 1'b1;

  typedef struct packed {
    logic                      action;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      last;
  } res_t;

  // Operation applied alike by every cell of the chain.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SORT,
    OP_ROTATE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             phase;
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] count;
  } cell_ctrl_t;

endpackage

### hdl/sims_cell.sv
// ----------------------------------------------------------------------------
// Sorted sequence store cell
// Holds one entry of the sequence and exchanges it with its neighbours for
// shifted inserts, odd-even transposition sorting and rotation on readout.
// ----------------------------------------------------------------------------
module sims_cell #(
  parameter int INDEX = 0
) (
  input  logic                              clk,
  input  sims_pkg::cell_ctrl_t              ctrl,
  input  logic signed [sims_pkg::VALUE_W-1:0] ins_value,
  input  logic signed [sims_pkg::VALUE_W-1:0] left,
  input  logic signed [sims_pkg::VALUE_W-1:0] right,
  input  logic signed [sims_pkg::VALUE_W-1:0] head,
  output logic signed [sims_pkg::VALUE_W-1:0] value
);

  localparam logic [sims_pkg::IDX_W-1:0] IDX  = sims_pkg::IDX_W'(INDEX);
  localparam logic [sims_pkg::IDX_W-1:0] IDX1 = sims_pkg::IDX_W'(INDEX + 1);
  // Phase in which this cell is the lower member of its compare pair.
  localparam logic LOWER_PHASE = (INDEX % 2) == 1;
  localparam logic HAS_LEFT    = INDEX > 0;

  logic signed [sims_pkg::VALUE_W-1:0] value_next;

  always_comb begin
    value_next = value;
    case (ctrl.op)
      sims_pkg::OP_INSERT: begin
        if (IDX == ctrl.pos) begin
          value_next = ins_value;
        end else if (IDX > ctrl.pos) begin
          value_next = left;
        end
      end
      sims_pkg::OP_SORT: begin
        if (ctrl.phase == LOWER_PHASE) begin
          if ((IDX1 < ctrl.count) && (right < value)) begin
            value_next = right;
          end
        end else if (HAS_LEFT && (IDX < ctrl.count) && (value < left)) begin
          value_next = left;
        end
      end
      sims_pkg::OP_ROTATE: begin
        if (IDX1 == ctrl.count) begin
          value_next = head;
        end else if (IDX1 < ctrl.count) begin
          value_next = right;
        end
      end
      default: begin
        value_next = value;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

### hdl/sequence_insert_and_merge_sort_core.sv
// ----------------------------------------------------------------------------
// Sorted sequence store
// Keeps up to DEPTH signed values in a chain of cells; inserts at a given
// position and, on request, sorts the sequence ascending and reads it out.
// ----------------------------------------------------------------------------
// Usage: command words arrive on cmd (cmd_valid / cmd_ready). An insert word
// places its value at the given position and moves later entries back by
// one cell; it yields no result word. An insert beyond the current count,
// or into a full store, is dropped without effect.
// A sort word runs one odd-even transposition phase per cycle across the
// chain, count phases in all, and then shifts the entries out on res
// (res_valid / res_ready), from the lowest value, one word per cycle while
// the receiver accepts, with last set on the final word. Readout rotates
// the chain, so the store is left sorted. A sort of an empty store yields
// nothing. A sort keeps cmd_ready low through the sorting phases of the
// chain and the readout, receiver stalls included. When the receiver
// stalls, the head cell and the readout counter hold and the word stays
// on res.
// Reset empties the store and returns to idle; cell contents are not reset.
// ----------------------------------------------------------------------------
module sequence_insert_and_merge_sort_core #(
  parameter int DEPTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  sims_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output sims_pkg::res_t res
);

  localparam logic [sims_pkg::IDX_W-1:0] DEPTH_I = sims_pkg::IDX_W'(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SORT,
    ST_EMIT
  } state_t;

  state_t                    state;
  logic [sims_pkg::IDX_W-1:0] count;
  logic [sims_pkg::IDX_W-1:0] step;
  logic                      phase;

  logic signed [sims_pkg::VALUE_W-1:0] cell_val [DEPTH];
  sims_pkg::cell_ctrl_t                ctrl;

  logic                       cmd_fire;
  logic                       res_fire;
  logic [sims_pkg::IDX_W-1:0] pos_ext;
  logic [sims_pkg::IDX_W-1:0] count_m1;
  logic                       ins_ok;

  assign cmd_ready = (state == ST_IDLE);
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign res_valid = (state == ST_EMIT);
  assign res_fire  = res_valid && res_ready;
  assign pos_ext   = sims_pkg::IDX_W'(cmd.position);
  assign count_m1  = count - 1'b1;
  // An insert is taken only when there is room and the position lies within
  // the current sequence or appends to it.
  assign ins_ok    = (count < DEPTH_I) && (pos_ext <= count);

  assign res.sorted_value = cell_val[0];
  assign res.last         = (step == count_m1);

  // Chain control: every cell sees the same operation word each cycle.
  always_comb begin
    ctrl.op    = sims_pkg::OP_HOLD;
    ctrl.phase = phase;
    ctrl.pos   = pos_ext;
    ctrl.count = count;
    case (state)
      ST_IDLE: begin
        if (cmd_fire && (cmd.action == sims_pkg::ACTION_INSERT) && ins_ok) begin
          ctrl.op = sims_pkg::OP_INSERT;
        end
      end
      ST_SORT: begin
        ctrl.op = sims_pkg::OP_SORT;
      end
      ST_EMIT: begin
        if (res_fire) begin
          ctrl.op = sims_pkg::OP_ROTATE;
        end
      end
      default: begin
        ctrl.op = sims_pkg::OP_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      step  <= '0;
      phase <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_fire) begin
            if (cmd.action == sims_pkg::ACTION_INSERT) begin
              if (ins_ok) begin
                count <= count + 1'b1;
              end
            end else if (count != '0) begin
              state <= ST_SORT;
              step  <= '0;
              phase <= 1'b0;
            end
          end
        end
        ST_SORT: begin
          phase <= ~phase;
          if (step == count_m1) begin
            state <= ST_EMIT;
            step  <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_EMIT: begin
          if (res_fire) begin
            if (step == count_m1) begin
              state <= ST_IDLE;
              step  <= '0;
            end else begin
              step <= step + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The chain itself: each cell talks to its two neighbours, and the last
  // live cell takes the head value when the sequence is rotated out.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [sims_pkg::VALUE_W-1:0] left_val;
    logic signed [sims_pkg::VALUE_W-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_val = cell_val[i];
    end else begin : g_mid_l
      assign left_val = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
    end

    sims_cell #(
      .INDEX(i)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .ins_value(cmd.value),
      .left     (left_val),
      .right    (right_val),
      .head     (cell_val[0]),
      .value    (cell_val[i])
    );
  end

endmodule
